[rtl/hcfp_pkg.sv]
// ----------------------------------------------------------------------------
// hcfp_pkg
// Shared types and constants of the header/command frame parser.
// ----------------------------------------------------------------------------
package hcfp_pkg;

    // Parse phases of the front end
    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_HDR3 = 3'd2,
        PH_CMD  = 3'd3,
        PH_LEN  = 3'd4,
        PH_DATA = 3'd5,
        PH_END  = 3'd6
    } phase_t;

    localparam logic [7:0] CMD_BASE = 8'h01;
    localparam logic [7:0] CMD_TILT = 8'h02;

    localparam logic AXIS_BASE = 1'b0;
    localparam logic AXIS_TILT = 1'b1;

    localparam logic [7:0] HDR_FIRST_RST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND_RST = 8'h55;
    localparam logic [7:0] HDR_THIRD_RST  = 8'hAA;

    // Register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [1:0] REG_HDR_THIRD  = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } hdr_cfg_t;

    typedef struct packed {
        logic [7:0] servo_value;
        logic       axis;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[rtl/header_command_frame_parser.sv]
// ----------------------------------------------------------------------------
// header_command_frame_parser
// Frame parser for header/command/length/payload byte streams that emits
// servo axis values.
//
// Usage:
//   s_tdata carries one received byte per item. After three header bytes
//   matching the APB registers come a command byte, a length byte, the
//   payload and one closing byte. On the closing byte, command 1 (base) or
//   2 (tilt) yields one item on m_tdata: the first payload byte of the
//   frame, or the one kept from an earlier frame when the length is zero.
//   Other commands yield nothing.
//   Throughput: one byte per cycle while the queue is not full; the front
//   parser state is registered. A result is written to the queue at the edge
//   that accepts the closing byte, then loaded from the queue into the output
//   register, which drives m_tvalid and m_tdata.
//   When m_tready stays low the output register holds and the queue fills;
//   s_tready drops only when the queue is full (QUEUE_DEPTH results).
//   Reset clears the parser to wait for the first header byte, empties the
//   queue and loads header registers with 0xAA, 0x55, 0xAA.
//   Registers: 0x0 header_first, 0x4 header_second, 0x8 header_third.
// ----------------------------------------------------------------------------
module header_command_frame_parser
#(
    parameter int QUEUE_DEPTH = hcfp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] axis, [8:1] servo_value, [15:9] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] hdr_first_reg,  hdr_first_next;
    logic [7:0] hdr_second_reg, hdr_second_next;
    logic [7:0] hdr_third_reg,  hdr_third_next;
    logic       cfg_write;

    hcfp_pkg::hdr_cfg_t       hdr_cfg;
    hcfp_pkg::queue_status_t  q_status;
    hcfp_pkg::result_t        push_data;
    hcfp_pkg::result_t        pop_data;
    hcfp_pkg::result_t        out_data;
    logic                     q_push;
    logic                     q_pop;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        hdr_first_next  = hdr_first_reg;
        hdr_second_next = hdr_second_reg;
        hdr_third_next  = hdr_third_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                hcfp_pkg::REG_HDR_FIRST:  hdr_first_next  = pwdata[7:0];
                hcfp_pkg::REG_HDR_SECOND: hdr_second_next = pwdata[7:0];
                hcfp_pkg::REG_HDR_THIRD:  hdr_third_next  = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            hcfp_pkg::REG_HDR_FIRST:  prdata = {24'd0, hdr_first_reg};
            hcfp_pkg::REG_HDR_SECOND: prdata = {24'd0, hdr_second_reg};
            hcfp_pkg::REG_HDR_THIRD:  prdata = {24'd0, hdr_third_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= hcfp_pkg::HDR_FIRST_RST;
            hdr_second_reg <= hcfp_pkg::HDR_SECOND_RST;
            hdr_third_reg  <= hcfp_pkg::HDR_THIRD_RST;
        end
        else
        begin
            hdr_first_reg  <= hdr_first_next;
            hdr_second_reg <= hdr_second_next;
            hdr_third_reg  <= hdr_third_next;
        end
    end

    assign hdr_cfg.first  = hdr_first_reg;
    assign hdr_cfg.second = hdr_second_reg;
    assign hdr_cfg.third  = hdr_third_reg;

    // ---------------- datapath ----------------
    hcfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .hdr_cfg   (hdr_cfg),
        .q_status  (q_status),
        .push      (q_push),
        .push_data (push_data)
    );

    hcfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    hcfp_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {7'd0, out_data.servo_value, out_data.axis};

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("result pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("result popped from empty queue");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |=> !q_status.empty)
        else $error("pushed result missing from queue");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !s_tready)
        else $error("input taken while queue full");
`endif

endmodule

[rtl/hcfp_front.sv]
// ----------------------------------------------------------------------------
// hcfp_front
// Byte-wise frame parser: tracks header, command, length and payload; on the
// closing byte of a base or tilt frame, pushes a servo result to the queue.
// ----------------------------------------------------------------------------
module hcfp_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_byte,
    input  hcfp_pkg::hdr_cfg_t       hdr_cfg,
    input  hcfp_pkg::queue_status_t  q_status,
    output logic                     push,
    output hcfp_pkg::result_t        push_data
);

    hcfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] length_reg,  length_next;
    logic [7:0] count_reg,   count_next;
    logic [7:0] first_reg,   first_next;
    logic       accept;
    logic [7:0] count_inc;

    assign in_ready  = !q_status.full;
    assign accept    = in_valid && in_ready;
    assign count_inc = count_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hcfp_pkg::PH_HDR1;
            command_reg <= '0;
            length_reg  <= '0;
            count_reg   <= '0;
            first_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        first_next   = first_reg;
        push         = 1'b0;
        push_data.servo_value = first_reg;
        push_data.axis        = (command_reg == hcfp_pkg::CMD_TILT) ?
                                hcfp_pkg::AXIS_TILT : hcfp_pkg::AXIS_BASE;
        if (accept)
        begin
            unique case (phase_reg)
                hcfp_pkg::PH_HDR1:
                begin
                    if (in_byte == hdr_cfg.first)
                        phase_next = hcfp_pkg::PH_HDR2;
                end
                // stay on a mismatch, do not fall back to the first byte
                hcfp_pkg::PH_HDR2:
                begin
                    if (in_byte == hdr_cfg.second)
                        phase_next = hcfp_pkg::PH_HDR3;
                end
                hcfp_pkg::PH_HDR3:
                begin
                    if (in_byte == hdr_cfg.third)
                        phase_next = hcfp_pkg::PH_CMD;
                end
                hcfp_pkg::PH_CMD:
                begin
                    command_next = in_byte;
                    phase_next   = hcfp_pkg::PH_LEN;
                end
                hcfp_pkg::PH_LEN:
                begin
                    length_next = in_byte;
                    count_next  = '0;
                    phase_next  = (in_byte != 8'd0) ? hcfp_pkg::PH_DATA
                                                    : hcfp_pkg::PH_END;
                end
                hcfp_pkg::PH_DATA:
                begin
                    // keep the first payload byte, only count the rest
                    if (count_reg == 8'd0)
                        first_next = in_byte;
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                        phase_next = hcfp_pkg::PH_END;
                end
                hcfp_pkg::PH_END:
                begin
                    phase_next = hcfp_pkg::PH_HDR1;
                    push = (command_reg == hcfp_pkg::CMD_BASE) ||
                           (command_reg == hcfp_pkg::CMD_TILT);
                end
                default:
                begin
                    phase_next = hcfp_pkg::PH_HDR1;
                end
            endcase
        end
    end

endmodule

[rtl/hcfp_queue.sv]
// ----------------------------------------------------------------------------
// hcfp_queue
// Small register FIFO of parsed results between front end and output stage.
// ----------------------------------------------------------------------------
module hcfp_queue
#(
    parameter int DEPTH = hcfp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hcfp_pkg::result_t        push_data,
    input  logic                     pop,
    output hcfp_pkg::result_t        pop_data,
    output hcfp_pkg::queue_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    hcfp_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[rtl/hcfp_out.sv]
// ----------------------------------------------------------------------------
// hcfp_out
// Output register stage: pulls results from the queue and presents them on
// the master stream until taken.
// ----------------------------------------------------------------------------
module hcfp_out
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  hcfp_pkg::queue_status_t  q_status,
    input  hcfp_pkg::result_t        q_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hcfp_pkg::result_t        out_data
);

    logic               valid_reg, valid_next;
    hcfp_pkg::result_t  data_reg;

    // refill when the slot is empty or being drained this cycle
    assign pop        = !q_status.empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= q_data;
    end

endmodule
